// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame bitmap allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, suspended while reset is asserted.
`define FBA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Condition that must never hold outside reset.
`define FBA_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `FBA_ASSERT(lbl, clk, rst_n, !(cond))

`endif

// ===== sv/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Types and constants shared by the frame bitmap allocator modules.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int unsigned FRAMES    = 4096;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned NWORDS    = FRAMES / WORD_BITS;
  localparam int unsigned WADDR_W   = $clog2(NWORDS);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);
  localparam int unsigned SCAN_W    = WADDR_W + 1;
  localparam int unsigned FRAME_W   = 12;
  localparam int unsigned CNT_W     = 13;
  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = CNT_W'(4096);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_TEST  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NOP     = 2'd1,
    ST_NO_FREE = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e              opcode;
    logic [FRAME_W-1:0]   frame_index;
    logic                 kernel_only;
    logic                 wr_allowed;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]   result_frame;
    logic                 present;
    logic                 writable;
    logic                 user_mode;
    logic                 in_use;
    status_e              status;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture the accepted transaction
    logic rd_req;      // read the word holding the request's frame
    logic scan_start;  // rewind the search pointer
    logic scan_step;   // issue the next search read
    logic apply;       // finish free / mark / test
    logic skip;        // alloc with a frame already held
    logic claim;       // set the free bit just found
    logic fail;        // search exhausted
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    opcode_e op;
    logic    has_frame;
    logic    found;
    logic    exhausted;
  } dp_sts_t;

endpackage

// ===== sv/fba_dp.sv =====
// ----------------------------------------------------------------------------
// fba_dp
// Datapath: bitmap memory with per-word valid bits, request and config
// registers, search pointer, free-bit finder and result register.
// ----------------------------------------------------------------------------
module fba_dp import fba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  in_item_t         in_item_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_data_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  output out_item_t        out_item_o,
  output logic             result_valid_o
);

  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rd_data_q;
  logic [WADDR_W-1:0]   rd_addr_q;
  logic [NWORDS-1:0]    vld_q;

  in_item_t             req_q;
  logic [CNT_W-1:0]     frame_count_q;
  logic [SCAN_W-1:0]    scan_ptr_q, scan_ptr_d;
  logic                 chk_q, chk_d;
  out_item_t            res_q, res_d;
  logic                 res_vld_q, res_vld_d;

  logic [CNT_W-BIT_W-1:0] cnt_words;
  logic [SCAN_W-1:0]      scan_lim;
  logic                   issue;
  logic                   re, we;
  logic [WADDR_W-1:0]     ra;
  logic [WORD_BITS-1:0]   wd, word, free_1h, bit_mask;
  logic [BIT_W-1:0]       free_idx;
  logic                   has_frame;

  // Search covers whole words below frame_count, capped at the bitmap size
  assign cnt_words = frame_count_q[CNT_W-1:BIT_W];
  assign scan_lim  = (cnt_words > (CNT_W-BIT_W)'(NWORDS)) ? SCAN_W'(NWORDS)
                                                          : SCAN_W'(cnt_words);

  // Words never written since reset read as all free
  assign word      = vld_q[rd_addr_q] ? rd_data_q : '0;
  assign free_1h   = ~word & (word + WORD_BITS'(1));
  assign bit_mask  = WORD_BITS'(1) << req_q.frame_index[BIT_W-1:0];
  assign has_frame = (req_q.frame_index != '0);

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (free_1h[i]) begin
        free_idx = free_idx | BIT_W'(i);
      end
    end
  end

  assign issue = cmd_i.scan_step && (scan_ptr_q < scan_lim);
  assign re    = cmd_i.rd_req || issue;
  assign ra    = cmd_i.rd_req ? req_q.frame_index[FRAME_W-1:BIT_W]
                              : scan_ptr_q[WADDR_W-1:0];

  assign sts_o.op        = req_q.opcode;
  assign sts_o.has_frame = has_frame;
  assign sts_o.found     = chk_q && (word != '1);
  assign sts_o.exhausted = !chk_q && (scan_ptr_q >= scan_lim);

  // Write port and result
  always_comb begin
    we        = 1'b0;
    wd        = word;
    res_d     = '0;
    res_vld_d = 1'b0;
    if (cmd_i.apply) begin
      res_vld_d = 1'b1;
      res_d.status = ST_DONE;
      unique case (req_q.opcode)
        OP_FREE: begin
          we = has_frame;
          wd = word & ~bit_mask;
          if (!has_frame) begin
            res_d.status = ST_NOP;
          end
        end
        OP_MARK: begin
          we = 1'b1;
          wd = word | bit_mask;
        end
        OP_TEST: begin
          res_d.in_use = word[req_q.frame_index[BIT_W-1:0]];
        end
        default: ;
      endcase
    end
    if (cmd_i.skip) begin
      res_vld_d          = 1'b1;
      res_d.result_frame = req_q.frame_index;
      res_d.status       = ST_NOP;
    end
    if (cmd_i.claim) begin
      we                 = 1'b1;
      wd                 = word | free_1h;
      res_vld_d          = 1'b1;
      res_d.result_frame = FRAME_W'({rd_addr_q, free_idx});
      res_d.present      = 1'b1;
      res_d.writable     = req_q.wr_allowed;
      res_d.user_mode    = ~req_q.kernel_only;
      res_d.status       = ST_DONE;
    end
    if (cmd_i.fail) begin
      res_vld_d    = 1'b1;
      res_d.status = ST_NO_FREE;
    end
  end

  always_comb begin
    scan_ptr_d = scan_ptr_q;
    chk_d      = chk_q;
    if (cmd_i.scan_start) begin
      scan_ptr_d = '0;
      chk_d      = 1'b0;
    end else if (cmd_i.scan_step) begin
      chk_d = issue;
      if (issue) begin
        scan_ptr_d = scan_ptr_q + SCAN_W'(1);
      end
    end
  end

  // Bitmap memory, registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[rd_addr_q] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
      rd_addr_q <= ra;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[rd_addr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_item_i;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
      scan_ptr_q    <= '0;
      chk_q         <= 1'b0;
      res_vld_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        frame_count_q <= cfg_data_i;
      end
      scan_ptr_q <= scan_ptr_d;
      chk_q      <= chk_d;
      res_vld_q  <= res_vld_d;
    end
  end

  assign out_item_o     = res_q;
  assign result_valid_o = res_vld_q;

endmodule

// ===== sv/fba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fba_ctrl
// Controller: sequences decode, single-bit update and the first-fit search.
// ----------------------------------------------------------------------------
module fba_ctrl import fba_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_APPLY  = 4'b0100,
    S_SCAN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op == OP_ALLOC) begin
          if (sts_i.has_frame) begin
            cmd_o.skip = 1'b1;
            state_d    = S_IDLE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else begin
          cmd_o.rd_req = 1'b1;
          state_d      = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_IDLE;
      end
      S_SCAN: begin
        priority if (sts_i.found) begin
          cmd_o.claim = 1'b1;
          state_d     = S_IDLE;
        end else if (sts_i.exhausted) begin
          cmd_o.fail = 1'b1;
          state_d    = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== sv/frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// First-fit physical page-frame allocator over a one-bit-per-frame bitmap.
// ----------------------------------------------------------------------------
// channel   | signals                               | transaction when
// ----------+---------------------------------------+-------------------------
// request   | start, busy, in_item_i                | start && !busy
// result    | result_valid_o, out_item_o            | result_valid_o (1 cycle)
// config    | cfg_valid_i, cfg_ready_o, cfg_data_i  | cfg_valid_i && cfg_ready_o
//
// Free, mark, test: busy in decode and apply; alloc with a frame held: decode.
// Alloc search: decode, then scan to the first word with a free bit or, if none,
// through all words (words = min(frame_count/32, 128); no read if 0), one word
// read per cycle. Result strobed in the cycle busy falls.
// Reset leaves the bitmap all free at once (per-word valid bits, no clear pass)
// and frame_count at 4096. Results cannot be stalled; config is taken when idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_bitmap_allocator import fba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_item_i,
  output logic             result_valid_o,
  output out_item_t        out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = !busy;

  fba_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  fba_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_item_i      (in_item_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_item_o     (out_item_o),
    .result_valid_o (result_valid_o)
  );

  `FBA_ASSERT(a_accept_busy, clk_i, rst_ni, (start && !busy) |=> busy)
  `FBA_ASSERT(a_strobe_single, clk_i, rst_ni, result_valid_o |=> !result_valid_o)
  `FBA_ASSERT_NEVER(a_result_while_busy, clk_i, rst_ni, result_valid_o && busy)
  `FBA_ASSERT(a_present_done, clk_i, rst_ni,
    (result_valid_o && out_item_o.present) |-> (out_item_o.status == ST_DONE))

endmodule
